// File: hw/rtl/unison_oscillator_panner_core_assert.svh
// assertion macros shared by the unison oscillator panner rtl
// no dependencies; included by files that carry concurrent checks
`ifndef UNISON_OSCILLATOR_PANNER_CORE_ASSERT_SVH
`define UNISON_OSCILLATOR_PANNER_CORE_ASSERT_SVH

// same-cycle implication
`define UOP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UOP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/uop_pkg.sv
// shared types, codes, tables and helpers of the unison oscillator panner
// no dependencies
package uop_pkg;

  localparam int unsigned MAX_VOICES_DEF = 8;

  localparam int unsigned DIV_W  = 56;
  localparam int unsigned DVS_W  = 16;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned MUL_AW = 40;
  localparam int unsigned MUL_BW = 18;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned ACC_W  = 38;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_BEGIN = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ARM   = 3'd4;

  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SAW    = 3'd1;
  localparam logic [2:0] WAVE_SQUARE = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  localparam logic [2:0] REG_WAVE   = 3'd0;
  localparam logic [2:0] REG_AMP    = 3'd1;
  localparam logic [2:0] REG_SPREAD = 3'd2;
  localparam logic [2:0] REG_VCOUNT = 3'd3;
  localparam logic [2:0] REG_ATTACK = 3'd4;

  // datapath operations
  localparam logic [4:0] OP_NOP    = 5'd0;
  localparam logic [4:0] OP_TSTART = 5'd1;
  localparam logic [4:0] OP_VWAVE  = 5'd2;
  localparam logic [4:0] OP_QT2    = 5'd3;
  localparam logic [4:0] OP_QIN    = 5'd4;
  localparam logic [4:0] OP_QMID   = 5'd5;
  localparam logic [4:0] OP_QRES   = 5'd6;
  localparam logic [4:0] OP_WSIN   = 5'd7;
  localparam logic [4:0] OP_VS     = 5'd8;
  localparam logic [4:0] OP_PDIV   = 5'd9;
  localparam logic [4:0] OP_PAN    = 5'd10;
  localparam logic [4:0] OP_TR     = 5'd11;
  localparam logic [4:0] OP_GR     = 5'd12;
  localparam logic [4:0] OP_ACCR   = 5'd13;
  localparam logic [4:0] OP_ACCL   = 5'd14;
  localparam logic [4:0] OP_NORML  = 5'd15;
  localparam logic [4:0] OP_NORMR  = 5'd16;
  localparam logic [4:0] OP_ATTL   = 5'd17;
  localparam logic [4:0] OP_ATTR   = 5'd18;
  localparam logic [4:0] OP_ATTD   = 5'd19;
  localparam logic [4:0] OP_ATTLQ  = 5'd20;
  localparam logic [4:0] OP_ATTRQ  = 5'd21;
  localparam logic [4:0] OP_OUT    = 5'd22;
  localparam logic [4:0] OP_BCLR   = 5'd23;
  localparam logic [4:0] OP_BDIV   = 5'd24;
  localparam logic [4:0] OP_BSTEP  = 5'd25;
  localparam logic [4:0] OP_EBLK   = 5'd26;
  localparam logic [4:0] OP_LOAD   = 5'd27;
  localparam logic [4:0] OP_ARM    = 5'd28;

  localparam logic [15:0] INV_SQRT [16] = '{
    16'd32768, 16'd23170, 16'd18919, 16'd16384, 16'd14654, 16'd13377, 16'd12385, 16'd11585,
    16'd10923, 16'd10362, 16'd9880,  16'd9459,  16'd9088,  16'd8758,  16'd8461,  16'd8192
  };

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         voice_index;
    logic signed [31:0] increment_value;
    logic [12:0]        block_length;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    logic signed [23:0] center_sample;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  wave_type;
    logic [15:0] amplitude;
    logic [15:0] pan_spread;
    logic [3:0]  voice_count;
    logic [15:0] attack_length;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic       latch;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       amp_zero;
    logic       is_sine;
    logic       att_active;
    logic       vlast_tick;
    logic       vlast_all;
    logic       div_busy;
    logic       out_free;
  } stat_t;

  // signed shift right that rounds toward zero
  function automatic logic signed [MUL_PW-1:0] trunc_shr(input logic signed [MUL_PW-1:0] x,
                                                         input int unsigned k);
    logic signed [MUL_PW-1:0] bias;
    bias = x[MUL_PW-1] ? ((MUL_PW'(1) <<< k) - MUL_PW'(1)) : '0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [MUL_PW-1:0] x);
    logic signed [23:0] r;
    if (x > MUL_PW'(8388607)) r = 24'sh7FFFFF;
    else if (x < -MUL_PW'(8388608)) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/unison_oscillator_panner_core.sv
// top level of the unison oscillator panner: apb registers, controller, datapath
// depends on uop_pkg, uop_ctrl and uop_dp
//
// One item is taken at a time. A tick with nonzero amplitude steps through each active
// voice, plus the attack scaling while the attack ramp runs. It uses the shared divider
// (one quotient bit per cycle over 56 bits) once per voice for the pan position and twice
// per tick for the attack scale. A begin-block item with nonzero amplitude runs the glide
// step divisions for all MAX_VOICES voice slots. A finished sample waits in the output
// register while the next item is taken.
module unison_oscillator_panner_core #(
  parameter int unsigned MAX_VOICES = uop_pkg::MAX_VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uop_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uop_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import uop_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_type     <= WAVE_SINE;
      cfg_q.amplitude     <= 16'd0;
      cfg_q.pan_spread    <= 16'd0;
      cfg_q.voice_count   <= 4'd1;
      cfg_q.attack_length <= 16'd480;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVE:   cfg_q.wave_type     <= pwdata[2:0];
        REG_AMP:    cfg_q.amplitude     <= pwdata[15:0];
        REG_SPREAD: cfg_q.pan_spread    <= pwdata[15:0];
        REG_VCOUNT: cfg_q.voice_count   <= pwdata[3:0];
        REG_ATTACK: cfg_q.attack_length <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAVE:   prdata = {29'h0, cfg_q.wave_type};
      REG_AMP:    prdata = {16'h0, cfg_q.amplitude};
      REG_SPREAD: prdata = {16'h0, cfg_q.pan_spread};
      REG_VCOUNT: prdata = {28'h0, cfg_q.voice_count};
      REG_ATTACK: prdata = {16'h0, cfg_q.attack_length};
      default:    prdata = 32'h0;
    endcase
  end

  uop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  uop_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_i       (cfg_q),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hw/rtl/uop_div.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle
// depends on uop_pkg
module uop_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [uop_pkg::DIV_W-1:0] dividend_i,
  input  logic [uop_pkg::DVS_W-1:0]      divisor_i,
  output logic                           busy_o,
  output logic signed [uop_pkg::DIV_W-1:0] quot_o
);
  import uop_pkg::*;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [DIV_W-1:0] qsh_q, qsh_d;
  logic [DVS_W:0]   rem_q, rem_d, shifted;
  logic [DVS_W-1:0] dvs_q;
  logic             ge;

  always_comb begin
    shifted = {rem_q[DVS_W-1:0], qsh_q[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? shifted - {1'b0, dvs_q} : shifted;
    qsh_d   = {qsh_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      qsh_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      qsh_q <= qsh_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed(qsh_q) : $signed(qsh_q);

endmodule

// File: hw/rtl/uop_dp.sv
// datapath: voice state, shared multiplier, divider, accumulators, output register
// depends on uop_pkg and uop_div
module uop_dp #(
  parameter int unsigned MAX_VOICES = uop_pkg::MAX_VOICES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uop_pkg::cmd_t     cmd_i,
  output uop_pkg::stat_t    stat_o,
  input  uop_pkg::cfg_t     cfg_i,
  input  uop_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output uop_pkg::out_item_t out_item_o
);
  import uop_pkg::*;

  localparam int unsigned VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VOICES + 1);

  logic [31:0] phase_q  [MAX_VOICES];
  logic [31:0] incr_q   [MAX_VOICES];
  logic [31:0] target_q [MAX_VOICES];
  logic [31:0] step_q   [MAX_VOICES];
  logic [15:0] att_rem_q;
  logic [31:0] lfsr_q;

  in_item_t            item_q;
  logic [CW-1:0]       vcnt_q;
  logic [16:0]         t_q, t2_q, qres_q, pan_q, gr_q;
  logic [15:0]         inner_q, mid_q;
  logic                neg_q;
  logic signed [16:0]  w_q;
  logic signed [32:0]  vs_q;
  logic signed [ACC_W-1:0] lacc_q, racc_q;
  logic signed [DIV_W-1:0] att_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [VW-1:0] vsel;
  logic [4:0]    n;
  logic          active;
  logic [15:0]   spread, len, num;
  logic [31:0]   p, lfsr_nx;
  logic signed [16:0] saw, tri_w, noise, w_nx;
  logic [16:0]   saw_abs, sin_arg;
  logic [17:0]   tri_x;
  logic signed [17:0] d;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic                div_start, div_busy;
  logic signed [DIV_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0]    div_dvs;
  logic signed [MUL_PW-1:0] l_s, r_s, c_s;
  logic                out_free;

  assign vsel   = vcnt_q[VW-1:0];
  assign n      = (cfg_i.voice_count == 4'd0) ? 5'd1 :
                  ({1'b0, cfg_i.voice_count} > 5'(MAX_VOICES)) ? 5'(MAX_VOICES) :
                  {1'b0, cfg_i.voice_count};
  assign active = 5'(vcnt_q) < n;
  assign spread = (cfg_i.pan_spread > 16'd32768) ? 16'd32768 : cfg_i.pan_spread;
  assign len    = (cfg_i.attack_length == 16'd0) ? 16'd1 : cfg_i.attack_length;
  assign num    = (att_rem_q >= len) ? 16'd0 : len - att_rem_q;

  // waveform of the current voice from its old phase
  always_comb begin
    p       = phase_q[vsel];
    saw     = $signed({1'b0, p[31:16]}) - 17'sd32768;
    saw_abs = saw[16] ? 17'(-saw) : 17'(saw);
    tri_x   = {saw_abs, 1'b0} - 18'd32768;
    tri_w   = $signed(tri_x[16:0]);
    lfsr_nx = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_MASK : 32'h0);
    noise   = $signed({1'b0, lfsr_nx[31:16]}) - 17'sd32768;
    sin_arg = p[30] ? 17'd32768 - {2'b0, p[29:15]} : {2'b0, p[29:15]};
    case (cfg_i.wave_type)
      WAVE_SAW:    w_nx = saw;
      WAVE_SQUARE: w_nx = p[31] ? -17'sd16384 : 17'sd16384;
      WAVE_TRI:    w_nx = tri_w;
      WAVE_NOISE:  w_nx = noise;
      default:     w_nx = '0;
    endcase
  end

  assign d = (n > 5'd1) ? $signed(div_quot[17:0]) - 18'sd32768 : 18'sd0;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_QT2:   begin mul_a = MUL_AW'({1'b0, t_q});  mul_b = $signed({1'b0, t_q}); end
      OP_QIN:   begin mul_a = MUL_AW'({1'b0, t2_q}); mul_b = $signed({2'b0, SIN_C}); end
      OP_QMID:  begin mul_a = MUL_AW'({1'b0, t2_q}); mul_b = $signed({2'b0, inner_q}); end
      OP_QRES:  begin mul_a = MUL_AW'({1'b0, mid_q}); mul_b = $signed({1'b0, t_q}); end
      OP_VS:    begin mul_a = MUL_AW'(w_q);  mul_b = $signed({2'b0, cfg_i.amplitude}); end
      OP_PAN:   begin mul_a = MUL_AW'(d);    mul_b = $signed({2'b0, spread}); end
      OP_ACCR:  begin mul_a = MUL_AW'(vs_q); mul_b = $signed({1'b0, gr_q}); end
      OP_ACCL:  begin mul_a = MUL_AW'(vs_q); mul_b = $signed({1'b0, qres_q}); end
      OP_NORML: begin mul_a = MUL_AW'(lacc_q); mul_b = $signed({2'b0, INV_SQRT[4'(n - 5'd1)]}); end
      OP_NORMR: begin mul_a = MUL_AW'(racc_q); mul_b = $signed({2'b0, INV_SQRT[4'(n - 5'd1)]}); end
      OP_ATTL:  begin mul_a = MUL_AW'(lacc_q); mul_b = $signed({2'b0, num}); end
      OP_ATTR:  begin mul_a = MUL_AW'(racc_q); mul_b = $signed({2'b0, num}); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider feed
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 16'd1;
    case (cmd_i.op)
      OP_PDIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'({vcnt_q, 16'h0});
        div_dvs   = (n > 5'd1) ? 16'(n - 5'd1) : 16'd1;
      end
      OP_BDIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'($signed(target_q[vsel])) - DIV_W'($signed(incr_q[vsel]));
        div_dvs   = (item_q.block_length == 13'd0) ? 16'd1 : {3'b0, item_q.block_length};
      end
      OP_ATTD: begin
        div_start = 1'b1;
        div_dvd   = att_q;
        div_dvs   = len;
      end
      default: div_start = 1'b0;
    endcase
  end

  uop_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign l_s = trunc_shr(MUL_PW'(lacc_q), 10);
  assign r_s = trunc_shr(MUL_PW'(racc_q), 10);
  assign c_s = trunc_shr(l_s + r_s, 1);
  assign out_free = !out_valid_q || !out_stall_i;

  // voice state and control-visible state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        phase_q[i]  <= '0;
        incr_q[i]   <= '0;
        target_q[i] <= '0;
        step_q[i]   <= '0;
      end
      att_rem_q   <= '0;
      lfsr_q      <= 32'd1;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_TSTART, OP_BCLR: vcnt_q <= '0;
        OP_VWAVE: begin
          incr_q[vsel] <= incr_q[vsel] + step_q[vsel];
          if (cfg_i.wave_type == WAVE_NOISE) lfsr_q <= lfsr_nx;
        end
        OP_ACCL: begin
          phase_q[vsel] <= phase_q[vsel] + incr_q[vsel];
          vcnt_q        <= vcnt_q + CW'(1);
        end
        OP_BSTEP: begin
          step_q[vsel] <= active ? div_quot[31:0] : 32'h0;
          vcnt_q       <= vcnt_q + CW'(1);
        end
        OP_EBLK: begin
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (5'(i) < n) incr_q[i] <= target_q[i];
          end
        end
        OP_LOAD: begin
          for (int i = 0; i < MAX_VOICES; i++) begin
            if (5'(i) == {2'b0, item_q.voice_index}) target_q[i] <= item_q.increment_value;
          end
        end
        OP_ARM:   att_rem_q <= cfg_i.attack_length;
        OP_ATTRQ: att_rem_q <= att_rem_q - 16'd1;
        default:  ;
      endcase
    end
  end

  // arithmetic scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) item_q <= in_item_i;
    case (cmd_i.op)
      OP_TSTART: begin
        lacc_q <= '0;
        racc_q <= '0;
      end
      OP_VWAVE: begin
        w_q   <= w_nx;
        t_q   <= sin_arg;
        neg_q <= p[31];
      end
      OP_QT2:  t2_q    <= mul_p[31:15];
      OP_QIN:  inner_q <= SIN_B - mul_p[30:15];
      OP_QMID: mid_q   <= SIN_A - mul_p[30:15];
      OP_QRES: qres_q  <= mul_p[31:15];
      OP_WSIN: w_q     <= neg_q ? -$signed(qres_q) : $signed(qres_q);
      OP_VS:   vs_q    <= mul_p[32:0];
      OP_PAN:  pan_q   <= 17'(MUL_PW'(16384) + trunc_shr(mul_p, 16));
      OP_TR:   t_q     <= pan_q;
      OP_GR: begin
        gr_q <= qres_q;
        t_q  <= 17'd32768 - pan_q;
      end
      OP_ACCR:  racc_q <= racc_q + ACC_W'(trunc_shr(mul_p, 15));
      OP_ACCL:  lacc_q <= lacc_q + ACC_W'(trunc_shr(mul_p, 15));
      OP_NORML: lacc_q <= ACC_W'(trunc_shr(mul_p, 15));
      OP_NORMR: racc_q <= ACC_W'(trunc_shr(mul_p, 15));
      OP_ATTL, OP_ATTR: att_q <= DIV_W'(mul_p);
      OP_ATTLQ: lacc_q <= ACC_W'(div_quot);
      OP_ATTRQ: racc_q <= ACC_W'(div_quot);
      OP_OUT: begin
        if (cfg_i.amplitude == 16'd0) begin
          out_q <= '0;
        end else begin
          out_q.left_sample   <= sat24(l_s);
          out_q.right_sample  <= sat24(r_s);
          out_q.center_sample <= sat24(c_s);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.kind       = item_q.kind;
  assign stat_o.amp_zero   = cfg_i.amplitude == 16'd0;
  assign stat_o.is_sine    = cfg_i.wave_type == WAVE_SINE;
  assign stat_o.att_active = att_rem_q != 16'd0;
  assign stat_o.vlast_tick = 5'(vcnt_q) == n - 5'd1;
  assign stat_o.vlast_all  = vcnt_q == CW'(MAX_VOICES - 1);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/uop_ctrl.sv
// controller: sequences datapath operations for each input item
// depends on uop_pkg and the assertion macro header
`include "unison_oscillator_panner_core_assert.svh"

module uop_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  uop_pkg::stat_t stat_i,
  output uop_pkg::cmd_t  cmd_o
);
  import uop_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_VWAVE = 5'd2;
  localparam logic [4:0] S_QS0   = 5'd3;
  localparam logic [4:0] S_QS1   = 5'd4;
  localparam logic [4:0] S_QS2   = 5'd5;
  localparam logic [4:0] S_QS3   = 5'd6;
  localparam logic [4:0] S_WSIN  = 5'd7;
  localparam logic [4:0] S_VS    = 5'd8;
  localparam logic [4:0] S_PDIV  = 5'd9;
  localparam logic [4:0] S_PWAIT = 5'd10;
  localparam logic [4:0] S_PAN   = 5'd11;
  localparam logic [4:0] S_TR    = 5'd12;
  localparam logic [4:0] S_GR    = 5'd13;
  localparam logic [4:0] S_ACCR  = 5'd14;
  localparam logic [4:0] S_ACCL  = 5'd15;
  localparam logic [4:0] S_NORML = 5'd16;
  localparam logic [4:0] S_NORMR = 5'd17;
  localparam logic [4:0] S_ATTL  = 5'd18;
  localparam logic [4:0] S_ATTLD = 5'd19;
  localparam logic [4:0] S_ATTLW = 5'd20;
  localparam logic [4:0] S_ATTR  = 5'd21;
  localparam logic [4:0] S_ATTRD = 5'd22;
  localparam logic [4:0] S_ATTRW = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;
  localparam logic [4:0] S_BDIV  = 5'd25;
  localparam logic [4:0] S_BWAIT = 5'd26;

  logic [4:0] state_q, state_d;
  logic [4:0] ret_q, ret_d;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_o.op  = OP_NOP;
    cmd_o.latch = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        case (stat_i.kind)
          KIND_TICK: begin
            if (stat_i.amp_zero) begin
              state_d = S_OUT;
            end else begin
              cmd_o.op = OP_TSTART;
              state_d  = S_VWAVE;
            end
          end
          KIND_LOAD: cmd_o.op = OP_LOAD;
          KIND_BEGIN: begin
            if (!stat_i.amp_zero) begin
              cmd_o.op = OP_BCLR;
              state_d  = S_BDIV;
            end
          end
          KIND_END: if (!stat_i.amp_zero) cmd_o.op = OP_EBLK;
          KIND_ARM: cmd_o.op = OP_ARM;
          default:  cmd_o.op = OP_NOP;
        endcase
      end
      S_VWAVE: begin
        cmd_o.op = OP_VWAVE;
        if (stat_i.is_sine) begin
          ret_d   = S_WSIN;
          state_d = S_QS0;
        end else begin
          state_d = S_VS;
        end
      end
      // quarter-wave sine polynomial, one product per step
      S_QS0: begin cmd_o.op = OP_QT2;  state_d = S_QS1; end
      S_QS1: begin cmd_o.op = OP_QIN;  state_d = S_QS2; end
      S_QS2: begin cmd_o.op = OP_QMID; state_d = S_QS3; end
      S_QS3: begin cmd_o.op = OP_QRES; state_d = ret_q; end
      S_WSIN: begin cmd_o.op = OP_WSIN; state_d = S_VS; end
      S_VS:   begin cmd_o.op = OP_VS;   state_d = S_PDIV; end
      S_PDIV: begin cmd_o.op = OP_PDIV; state_d = S_PWAIT; end
      S_PWAIT: if (!stat_i.div_busy) state_d = S_PAN;
      S_PAN: begin cmd_o.op = OP_PAN; state_d = S_TR; end
      S_TR: begin
        cmd_o.op = OP_TR;
        ret_d    = S_GR;
        state_d  = S_QS0;
      end
      S_GR: begin
        cmd_o.op = OP_GR;
        ret_d    = S_ACCR;
        state_d  = S_QS0;
      end
      S_ACCR: begin cmd_o.op = OP_ACCR; state_d = S_ACCL; end
      S_ACCL: begin
        cmd_o.op = OP_ACCL;
        state_d  = stat_i.vlast_tick ? S_NORML : S_VWAVE;
      end
      S_NORML: begin cmd_o.op = OP_NORML; state_d = S_NORMR; end
      S_NORMR: begin
        cmd_o.op = OP_NORMR;
        state_d  = stat_i.att_active ? S_ATTL : S_OUT;
      end
      S_ATTL:  begin cmd_o.op = OP_ATTL; state_d = S_ATTLD; end
      S_ATTLD: begin cmd_o.op = OP_ATTD; state_d = S_ATTLW; end
      S_ATTLW: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ATTLQ;
          state_d  = S_ATTR;
        end
      end
      S_ATTR:  begin cmd_o.op = OP_ATTR; state_d = S_ATTRD; end
      S_ATTRD: begin cmd_o.op = OP_ATTD; state_d = S_ATTRW; end
      S_ATTRW: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ATTRQ;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      S_BDIV: begin cmd_o.op = OP_BDIV; state_d = S_BWAIT; end
      S_BWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_BSTEP;
          state_d  = stat_i.vlast_all ? S_IDLE : S_BDIV;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  `UOP_ASSERT_IMP(a_div_free, clk_i, rst_ni, cmd_o.op == OP_PDIV || cmd_o.op == OP_BDIV || cmd_o.op == OP_ATTD, !stat_i.div_busy, "divider started while busy")
  `UOP_ASSERT_IMP(a_out_free, clk_i, rst_ni, cmd_o.op == OP_OUT, stat_i.out_free, "result written over a pending transfer")
  `UOP_ASSERT_NXT(a_tick_runs, clk_i, rst_ni, state_q == S_DISP && stat_i.kind == KIND_TICK, state_q != S_IDLE, "tick dropped without a result")

endmodule

// File: tb/tb_unison_oscillator_panner_core.sv
// self-checking testbench of the unison oscillator panner core
// depends on uop_pkg and unison_oscillator_panner_core; predicts each tick sample in-line
`timescale 1ns / 100ps

module tb_unison_oscillator_panner_core;
  import uop_pkg::*;

  localparam int NV = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  unison_oscillator_panner_core dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] ph [NV];
  logic [31:0] inc [NV];
  logic [31:0] tgt [NV];
  logic [31:0] stp [NV];
  logic [15:0] att_rem;
  logic [31:0] lfsr;
  cfg_t cfg;

  out_item_t sample_q[$];
  int errors = 0;
  int n_items = 0;
  int n_samples = 0;
  bit sink_idle_en = 1'b1;
  bit src_idle_en = 1'b1;
  bit hold_sink = 1'b0;

  function automatic longint qsin(longint t);
    longint t2, inner, mid;
    t2 = (t * t) >>> 15;
    inner = SIN_B - ((t2 * SIN_C) >>> 15);
    mid = SIN_A - ((t2 * inner) >>> 15);
    return (t * mid) >>> 15;
  endfunction

  function automatic longint voice_wave(logic [31:0] p);
    longint saw, s;
    logic [14:0] f;
    logic lsb;
    saw = longint'(p[31:16]) - 32768;
    case (cfg.wave_type)
      WAVE_SINE: begin
        f = p[29:15];
        s = qsin(p[30] ? 32768 - longint'(f) : longint'(f));
        return p[31] ? -s : s;
      end
      WAVE_SAW: return saw;
      WAVE_SQUARE: return p[31] ? -16384 : 16384;
      WAVE_TRI: return 2 * (saw < 0 ? -saw : saw) - 32768;
      WAVE_NOISE: begin
        lsb = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ LFSR_MASK;
        return longint'(lfsr[31:16]) - 32768;
      end
      default: return 0;
    endcase
  endfunction

  function automatic longint clip24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic int voices_on();
    int n;
    n = cfg.voice_count;
    if (n < 1) n = 1;
    if (n > NV) n = NV;
    return n;
  endfunction

  function automatic void predict_tick();
    out_item_t o;
    int n;
    longint spread, la, ra, vs, d, pan, len, rem, num, l, r, c;
    n = voices_on();
    spread = cfg.pan_spread > 32768 ? 32768 : cfg.pan_spread;
    la = 0;
    ra = 0;
    o = '0;
    if (cfg.amplitude != 0) begin
      for (int v = 0; v < n; v++) begin
        inc[v] = inc[v] + stp[v];
        vs = voice_wave(ph[v]) * longint'(cfg.amplitude);
        d = (n > 1) ? (longint'(v) * 65536 / (n - 1) - 32768) : 0;
        pan = 16384 + d * spread / 65536;
        la += vs * qsin(32768 - pan) / 32768;
        ra += vs * qsin(pan) / 32768;
        ph[v] = ph[v] + inc[v];
      end
      la = la * longint'(INV_SQRT[n - 1]) / 32768;
      ra = ra * longint'(INV_SQRT[n - 1]) / 32768;
      if (att_rem != 0) begin
        len = cfg.attack_length < 1 ? 1 : cfg.attack_length;
        rem = att_rem;
        num = rem >= len ? 0 : len - rem;
        la = la * num / len;
        ra = ra * num / len;
        att_rem = att_rem - 1;
      end
      l = la / 1024;
      r = ra / 1024;
      c = (l + r) / 2;
      o.left_sample = 24'(clip24(l));
      o.right_sample = 24'(clip24(r));
      o.center_sample = 24'(clip24(c));
    end
    sample_q.push_back(o);
  endfunction

  function automatic void predict_item(in_item_t it);
    int n;
    longint diff, bl;
    n = voices_on();
    case (it.kind)
      KIND_TICK: predict_tick();
      KIND_LOAD: tgt[it.voice_index] = it.increment_value;
      KIND_BEGIN: begin
        if (cfg.amplitude != 0) begin
          bl = it.block_length == 0 ? 1 : it.block_length;
          for (int v = 0; v < NV; v++) begin
            diff = longint'($signed(tgt[v])) - longint'($signed(inc[v]));
            stp[v] = (v < n) ? 32'(diff / bl) : 32'd0;
          end
        end
      end
      KIND_END: begin
        if (cfg.amplitude != 0)
          for (int v = 0; v < n; v++) inc[v] = tgt[v];
      end
      KIND_ARM: att_rem = cfg.attack_length;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_item_t w;
      if (sample_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        w = sample_q.pop_front();
        n_samples++;
        if (out_item_o.left_sample !== w.left_sample)
          report_mismatch("left", out_item_o.left_sample, w.left_sample);
        if (out_item_o.right_sample !== w.right_sample)
          report_mismatch("right", out_item_o.right_sample, w.right_sample);
        if (out_item_o.center_sample !== w.center_sample)
          report_mismatch("center", out_item_o.center_sample, w.center_sample);
      end
    end
  end

  // receiver stall: random bursts, or a long hold-off when asked
  initial begin
    int k;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_stall_i <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (k - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(it);
    n_items++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (1400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WAVE: cfg.wave_type = val[2:0];
      REG_AMP: cfg.amplitude = val[15:0];
      REG_SPREAD: cfg.pan_spread = val[15:0];
      REG_VCOUNT: cfg.voice_count = val[3:0];
      REG_ATTACK: cfg.attack_length = val[15:0];
      default: ;
    endcase
  endtask

  task automatic setup(int w, int amp, int spr, int vc, int al);
    go_idle();
    write_reg(REG_WAVE, w);
    write_reg(REG_AMP, amp);
    write_reg(REG_SPREAD, spr);
    write_reg(REG_VCOUNT, vc);
    write_reg(REG_ATTACK, al);
  endtask

  function automatic in_item_t mk(logic [2:0] k, logic [2:0] vi, logic [31:0] iv,
                                  logic [12:0] bl);
    in_item_t it;
    it.kind = k;
    it.voice_index = vi;
    it.increment_value = iv;
    it.block_length = bl;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return mk(KIND_TICK, 3'($urandom), $urandom, 13'($urandom));
    if (r < 75) return mk(KIND_LOAD, 3'($urandom), $urandom, 13'($urandom));
    if (r < 85) return mk(KIND_BEGIN, 3'($urandom), $urandom, 13'($urandom_range(1, 64)));
    if (r < 89) return mk(KIND_BEGIN, 3'($urandom), $urandom, 13'($urandom));
    if (r < 94) return mk(KIND_END, 3'($urandom), $urandom, 13'($urandom));
    if (r < 97) return mk(KIND_ARM, 3'($urandom), $urandom, 13'($urandom));
    return mk(3'($urandom_range(5, 7)), 3'($urandom), $urandom, 13'($urandom));
  endfunction

  task automatic test_zero_amplitude();
    send_item(mk(KIND_LOAD, 0, 32'h0100_0000, 0));
    send_item(mk(KIND_BEGIN, 0, 0, 4));
    send_item(mk(KIND_END, 0, 0, 0));
    send_item(mk(KIND_TICK, 7, 32'hFFFF_FFFF, 13'h1FFF));
    send_item(mk(KIND_ARM, 0, 0, 0));
    send_item(mk(KIND_TICK, 0, 0, 0));
  endtask

  task automatic test_directed();
    setup(WAVE_SINE, 32768, 32768, 8, 1);
    for (int v = 0; v < NV; v++)
      send_item(mk(KIND_LOAD, 3'(v), v[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 0));
    send_item(mk(KIND_BEGIN, 0, 0, 0));
    send_item(mk(KIND_TICK, 0, 0, 0));
    send_item(mk(KIND_BEGIN, 0, 0, 13'h1FFF));
    send_item(mk(KIND_END, 0, 0, 0));
    send_item(mk(KIND_ARM, 0, 0, 0));
    send_item(mk(KIND_TICK, 0, 0, 0));
    send_item(mk(KIND_TICK, 0, 0, 0));
    send_item(mk(3'd5, 0, 0, 0));
    send_item(mk(3'd7, 7, 32'hFFFF_FFFF, 13'h1FFF));
    for (int w = 1; w <= 7; w++) begin
      setup(w, 65535, 65535, w == 5 ? 0 : 15, 65535);
      send_item(mk(KIND_ARM, 0, 0, 0));
      send_item(mk(KIND_TICK, 0, 0, 0));
      send_item(mk(KIND_TICK, 0, 0, 0));
    end
  endtask

  task automatic test_random(int count, bit calm);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        if (calm) setup(WAVE_SINE + i % 5, 32768, 16384, 3, 4);
        else setup($urandom_range(0, 5), $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 64));
      end
      send_item(rand_item());
    end
  endtask

  // receiver holds off long enough for several ticks to back up into the input
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (4000) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_item(mk(KIND_TICK, 0, 0, 0));
    join
  endtask

  initial begin
    for (int v = 0; v < NV; v++) begin
      ph[v] = '0;
      inc[v] = '0;
      tgt[v] = '0;
      stp[v] = '0;
    end
    att_rem = '0;
    lfsr = 32'd1;
    cfg = '{wave_type: 3'd0, amplitude: 16'd0, pan_spread: 16'd0, voice_count: 4'd1,
            attack_length: 16'd480};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_zero_amplitude();
    test_directed();
    test_backpressure();
    test_random(900, 1'b0);
    sink_idle_en = 1'b0;
    src_idle_en = 1'b0;
    test_random(230, 1'b1);
    go_idle();
    $display("covered %0d items and %0d checked samples over all waves and voice counts",
             n_items, n_samples);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
